>>> rtl/cts_pkg.sv
package cts_pkg;

  localparam int RAW_W = 19;
  localparam int K_W = 29;
  localparam int PROD_W = RAW_W + K_W;
  localparam int R_W = 32;
  localparam int X_W = 30;
  localparam int REM_W = 33;
  localparam int SQRT_STAGES = X_W;
  localparam int ACC_W = 36;
  localparam int MAG_W = 35;
  localparam int XLO_W = 15;
  localparam int XHI_W = X_W - XLO_W;
  localparam int PP_W = MAG_W + XLO_W;
  localparam int SUM_W = MAG_W + X_W;
  localparam int X_FRAC = 28;
  localparam int RND_W = SUM_W - X_FRAC;
  localparam int SAL_SHIFT = 8;
  localparam int SAL_W = 32;
  localparam int NCOEF = 6;

  localparam logic [63:0] RECIP_FULL =
      (((64'd1 << 34) * 64'd10000) + 64'd265324) / 64'd530648;
  localparam logic [K_W-1:0] RECIP_K = K_W'(RECIP_FULL);

  localparam logic [63:0] C5_MAG = ((64'd27081 << 24) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C4_MAG = ((64'd70261 << 24) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C3_MAG = ((64'd140941 << 24) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C2_MAG = ((64'd253851 << 24) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C1_MAG = ((64'd1692 << 24) + 64'd5000) / 64'd10000;
  localparam logic [63:0] C0_MAG = ((64'd8 << 24) + 64'd500) / 64'd1000;

  typedef logic signed [ACC_W-1:0] acc_t;

  // horner order, highest power first
  localparam acc_t POLY [NCOEF] = '{
    acc_t'(C5_MAG),
    acc_t'(64'd0 - C4_MAG),
    acc_t'(C3_MAG),
    acc_t'(C2_MAG),
    acc_t'(64'd0 - C1_MAG),
    acc_t'(C0_MAG)
  };

endpackage

>>> rtl/conductivity_to_salinity_core.sv
// conductivity to practical salinity, simplified series without temperature term
//
// input channel: in_valid / in_ready carry one conductivity sample, signed,
// mS/cm with 10 fraction bits; a transfer happens when both are high
// output channel: out_valid / out_ready carry salinity (PSU, 16 fraction bits)
// and negative_clamped; a negative sample gives salinity zero with the flag set
//
// stages: 2 ratio stages, 30 square root stages at one root bit each,
// 5 polynomial steps of 5 stages, 2 rounding stages
// throughput: one sample per cycle unless the output stalls; every stage is
// a register with its own valid bit
// stall: when out_ready is low, results hold and stages fill up behind the
// output; in_ready stays high while any stage is empty, so nothing is lost
// or repeated
// reset: rst clears all valid bits, pipeline is empty and in_ready is high
module conductivity_to_salinity_core
  import cts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] conductivity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] salinity,
  output logic               negative_clamped
);

  logic             ra_valid, ra_ready, ra_neg;
  logic [R_W-1:0]   ra_r;
  logic [NCOEF-1:0] hv;
  logic [NCOEF-1:0] hr;
  logic             hn  [NCOEF];
  acc_t             acc [NCOEF];
  logic [X_W-1:0]   hx  [NCOEF-1];
  logic [SAL_W-1:0] sal;

  cts_ratio u_ratio (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .conductivity (conductivity),
    .out_valid    (ra_valid),
    .out_ready    (ra_ready),
    .r_out        (ra_r),
    .neg_out      (ra_neg)
  );

  cts_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ra_valid),
    .in_ready  (ra_ready),
    .r_in      (ra_r),
    .neg_in    (ra_neg),
    .out_valid (hv[0]),
    .out_ready (hr[0]),
    .x_out     (hx[0]),
    .neg_out   (hn[0])
  );

  assign acc[0] = POLY[0];

  for (genvar k = 1; k < NCOEF; k++) begin : g_horner
    if (k < NCOEF - 1) begin : g_mid
      cts_horner_step u_step (
        .clk       (clk),
        .rst       (rst),
        .coef      (POLY[k]),
        .in_valid  (hv[k-1]),
        .in_ready  (hr[k-1]),
        .acc_in    (acc[k-1]),
        .x_in      (hx[k-1]),
        .neg_in    (hn[k-1]),
        .out_valid (hv[k]),
        .out_ready (hr[k]),
        .acc_out   (acc[k]),
        .x_out     (hx[k]),
        .neg_out   (hn[k])
      );
    end else begin : g_last
      cts_horner_step u_step (
        .clk       (clk),
        .rst       (rst),
        .coef      (POLY[k]),
        .in_valid  (hv[k-1]),
        .in_ready  (hr[k-1]),
        .acc_in    (acc[k-1]),
        .x_in      (hx[k-1]),
        .neg_in    (hn[k-1]),
        .out_valid (hv[k]),
        .out_ready (hr[k]),
        .acc_out   (acc[k]),
        .x_out     (),
        .neg_out   (hn[k])
      );
    end
  end

  cts_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hv[NCOEF-1]),
    .in_ready  (hr[NCOEF-1]),
    .acc_in    (acc[NCOEF-1]),
    .neg_in    (hn[NCOEF-1]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sal_out   (sal),
    .flag_out  (negative_clamped)
  );

  assign salinity = sal;

endmodule

>>> rtl/cts_ratio.sv
module cts_ratio
  import cts_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [19:0]      conductivity,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [R_W-1:0]          r_out,
  output logic                    neg_out
);

  logic              v1, v2;
  logic              neg1, neg2;
  logic [PROD_W-1:0] prod;
  logic [R_W-1:0]    ratio;
  logic              rdy1, rdy2;
  logic [PROD_W:0]   prod_rnd;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  // conductivity times fixed reciprocal of the standard
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      neg1 <= conductivity[19];
      prod <= PROD_W'(conductivity[RAW_W-1:0]) * PROD_W'(RECIP_K);
    end
  end

  assign prod_rnd = {1'b0, prod} + (PROD_W+1)'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      neg2  <= neg1;
      ratio <= prod_rnd[R_W+15:16];
    end
  end

  assign out_valid = v2;
  assign r_out     = ratio;
  assign neg_out   = neg2;

endmodule

>>> rtl/cts_isqrt.sv
module cts_isqrt
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [R_W-1:0]   r_in,
  input  logic             neg_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [X_W-1:0]   x_out,
  output logic             neg_out
);

  logic [SQRT_STAGES-1:0] vld;
  logic [SQRT_STAGES:0]   rdy;
  logic [SQRT_STAGES-1:0] neg;
  logic [REM_W-1:0]       rem  [SQRT_STAGES];
  logic [X_W-1:0]         root [SQRT_STAGES];
  logic [R_W-1:0]         bits [SQRT_STAGES];

  assign rdy[SQRT_STAGES] = out_ready;
  assign in_ready = rdy[0];

  // one root bit per stage, radicand is the ratio shifted up by 28
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic             v_prev;
    logic             neg_prev;
    logic [REM_W-1:0] rem_prev;
    logic [X_W-1:0]   root_prev;
    logic [R_W-1:0]   bits_prev;
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_prev    = in_valid;
      assign neg_prev  = neg_in;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign bits_prev = r_in;
    end else begin : g_next
      assign v_prev    = vld[i-1];
      assign neg_prev  = neg[i-1];
      assign rem_prev  = rem[i-1];
      assign root_prev = root[i-1];
      assign bits_prev = bits[i-1];
    end

    assign rdy[i]  = !vld[i] || rdy[i+1];
    assign rem_sh  = {rem_prev, bits_prev[R_W-1 -: 2]};
    assign trial   = {(REM_W+2-X_W-2)'(0), root_prev, 2'b01};
    assign ge      = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && v_prev) begin
        neg[i]  <= neg_prev;
        rem[i]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root[i] <= {root_prev[X_W-2:0], ge};
        bits[i] <= {bits_prev[R_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign x_out     = root[SQRT_STAGES-1];
  assign neg_out   = neg[SQRT_STAGES-1];

endmodule

>>> rtl/cts_horner_step.sv
module cts_horner_step
  import cts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  acc_t             coef,
  input  logic             in_valid,
  output logic             in_ready,
  input  acc_t             acc_in,
  input  logic [X_W-1:0]   x_in,
  input  logic             neg_in,
  output logic             out_valid,
  input  logic             out_ready,
  output acc_t             acc_out,
  output logic [X_W-1:0]   x_out,
  output logic             neg_out
);

  logic             v1, v2, v3, v4, v5;
  logic             rdy1, rdy2, rdy3, rdy4, rdy5;
  logic             sg1, sg2, sg3, sg4;
  logic             neg1, neg2, neg3, neg4, neg5;
  logic [X_W-1:0]   x1, x2, x3, x4, x5;
  logic [MAG_W-1:0] mag1, mag2;
  logic [PP_W-1:0]  plo2, plo3;
  logic [PP_W-1:0]  phi3;
  logic [RND_W-1:0] rnd4;
  acc_t             acc5;
  logic [ACC_W-1:0] acc_abs;
  logic [SUM_W-1:0] sum;
  logic [ACC_W+1:0] coef_x;
  logic [ACC_W+1:0] rnd_x;

  assign rdy5 = !v5 || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // sign and magnitude
  assign acc_abs = acc_in[ACC_W-1] ? (ACC_W'(0) - acc_in) : acc_in;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sg1  <= acc_in[ACC_W-1];
      mag1 <= acc_abs[MAG_W-1:0];
      x1   <= x_in;
      neg1 <= neg_in;
    end
  end

  // low partial product
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      sg2  <= sg1;
      mag2 <= mag1;
      x2   <= x1;
      neg2 <= neg1;
      plo2 <= PP_W'(mag1) * PP_W'(x1[XLO_W-1:0]);
    end
  end

  // high partial product
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      sg3  <= sg2;
      x3   <= x2;
      neg3 <= neg2;
      plo3 <= plo2;
      phi3 <= PP_W'(mag2) * PP_W'(x2[X_W-1 -: XHI_W]);
    end
  end

  // combine and round half away from zero
  assign sum = SUM_W'(plo3) + {phi3, XLO_W'(0)} + (SUM_W'(1) << (X_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      sg4  <= sg3;
      x4   <= x3;
      neg4 <= neg3;
      rnd4 <= sum[SUM_W-1:X_FRAC];
    end
  end

  // apply sign and add coefficient
  assign coef_x = {{2{coef[ACC_W-1]}}, coef};
  assign rnd_x  = (ACC_W+2)'(rnd4);

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      x5   <= x4;
      neg5 <= neg4;
      acc5 <= sg4 ? acc_t'(coef_x - rnd_x) : acc_t'(coef_x + rnd_x);
    end
  end

  assign out_valid = v5;
  assign acc_out   = acc5;
  assign x_out     = x5;
  assign neg_out   = neg5;

endmodule

>>> rtl/cts_round.sv
module cts_round
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  acc_t              acc_in,
  input  logic              neg_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SAL_W-1:0]  sal_out,
  output logic              flag_out
);

  localparam int Q_W = ACC_W - SAL_SHIFT + 1;

  logic             v1, v2;
  logic             rdy1, rdy2;
  logic             sg1, neg1;
  logic [ACC_W-1:0] mag1;
  logic [ACC_W:0]   mag_rnd;
  logic [Q_W-1:0]   q;
  logic [SAL_W-1:0] sal;
  logic             flag;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sg1  <= acc_in[ACC_W-1];
      neg1 <= neg_in;
      mag1 <= acc_in[ACC_W-1] ? (ACC_W'(0) - acc_in) : acc_in;
    end
  end

  // q24 to q16, half away from zero; magnitude stays well inside 32 bits
  assign mag_rnd = {1'b0, mag1} + (ACC_W+1)'(1 << (SAL_SHIFT - 1));
  assign q       = mag_rnd[ACC_W:SAL_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      flag <= neg1;
      if (neg1) begin
        sal <= '0;
      end else if (sg1) begin
        sal <= SAL_W'(0) - SAL_W'(q);
      end else begin
        sal <= SAL_W'(q);
      end
    end
  end

  assign out_valid = v2;
  assign sal_out   = sal;
  assign flag_out  = flag;

endmodule
